### hw/rtl/nst_pkg.sv
// Shared types, codes and helpers for the nearest table entry search.
package nst_pkg;

  localparam int CFG_W  = 9;
  localparam int POS_W  = 16;
  localparam int SQ_W   = 32;
  localparam int DIST_W = 34;
  localparam int ROOT_W = 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        entry_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] mid_curvature;
    logic signed [15:0] end_curvature;
  } in_item_t;

  typedef struct packed {
    logic              table_empty;
    logic [7:0]        best_index;
    logic [15:0]       arc_length;
    logic signed [15:0] best_mid_curvature;
    logic signed [15:0] best_end_curvature;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] yaw;
    logic signed [15:0] mid;
    logic signed [15:0] fin;
  } entry_t;

  typedef struct packed {
    logic start;    // latch query target, clear scan
    logic write;    // store the item as a table entry
    logic issue;    // read next entry
    logic publish;  // move result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic issue_left;
    logic busy;
    logic out_free;
  } dp_status_t;

  function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                               logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic [POS_W:0] m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (~d + 1'b1) : d;
    return m[POS_W-1:0];
  endfunction

endpackage

### hw/rtl/nst_chan_if.sv
// Valid/ready channel carrying one payload of type T.
interface nst_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/nst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/nst_ctrl.sv
// Controller: sequences loads, query scans and result hand-off.
module nst_ctrl import nst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_kind,
  output logic       req_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_kind == KIND_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = st.issue_left;
        if (!st.issue_left && !st.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/nst_datapath.sv
// Datapath: entry table, distance pipeline, best tracker, root unit, output register.
module nst_datapath import nst_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_t      cfg_data,
  input  in_item_t  item,
  input  dp_cmd_t   cmd,
  output dp_status_t st,
  output out_item_t res_data,
  output logic      res_valid,
  input  logic      res_ready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW = (CW > 8) ? CW : 8;

  localparam logic [1:0] RT_IDLE = 2'd0;
  localparam logic [1:0] RT_SQ   = 2'd1;
  localparam logic [1:0] RT_SUM  = 2'd2;
  localparam logic [1:0] RT_ITER = 2'd3;

  // configuration
  cfg_t entries_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  // clamped count of entries to search
  logic [EW-1:0] cnt_ext;
  logic [CW-1:0] cnt_clamped;

  always_comb begin
    cnt_ext = EW'(entries_in_use);
    if (cnt_ext > EW'(TABLE_DEPTH)) begin
      cnt_clamped = CW'(TABLE_DEPTH);
    end else begin
      cnt_clamped = cnt_ext[CW-1:0];
    end
  end

  // table
  logic [SW-1:0] slot_ext;
  logic          ram_we;
  entry_t        wr_entry;
  entry_t        rd_entry;
  logic [IW-1:0] waddr;

  assign slot_ext = SW'(item.entry_index);
  assign ram_we   = cmd.write && (slot_ext < SW'(TABLE_DEPTH));
  assign waddr    = slot_ext[IW-1:0];
  assign wr_entry = '{x: item.pos_x, y: item.pos_y, yaw: item.heading,
                      mid: item.mid_curvature, fin: item.end_curvature};

  logic [CW-1:0] addr;
  logic [CW-1:0] count;

  nst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wr_entry),
    .re   (cmd.issue),
    .raddr(addr[IW-1:0]),
    .rdata(rd_entry)
  );

  // query target
  logic signed [POS_W-1:0] tx;
  logic signed [POS_W-1:0] ty;
  logic signed [POS_W-1:0] th;
  logic                    empty;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tx    <= item.pos_x;
      ty    <= item.pos_y;
      th    <= item.heading;
      count <= cnt_clamped;
      empty <= (cnt_clamped == '0);
      addr  <= '0;
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end
  end

  // distance pipeline: read -> abs diffs -> squares -> sum -> compare
  logic v0, v1, v2, v3;
  logic [IW-1:0] idx0, idx1, idx2, idx3;
  logic signed [15:0] mid1, mid2, mid3;
  logic signed [15:0] fin1, fin2, fin3;
  logic [POS_W-1:0] ax, ay, ah;
  logic [SQ_W-1:0]  sx, sy, sh;
  logic [DIST_W-1:0] dist3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx0  <= addr[IW-1:0];
    idx1  <= idx0;
    ax    <= abs_diff(tx, rd_entry.x);
    ay    <= abs_diff(ty, rd_entry.y);
    ah    <= abs_diff(th, rd_entry.yaw);
    mid1  <= rd_entry.mid;
    fin1  <= rd_entry.fin;
    idx2  <= idx1;
    sx    <= SQ_W'(ax) * SQ_W'(ax);
    sy    <= SQ_W'(ay) * SQ_W'(ay);
    sh    <= SQ_W'(ah) * SQ_W'(ah);
    mid2  <= mid1;
    fin2  <= fin1;
    idx3  <= idx2;
    dist3 <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sh);
    mid3  <= mid2;
    fin3  <= fin2;
  end

  // best tracker; strict less-than keeps the lowest slot on ties
  logic               first;
  logic [DIST_W-1:0]  best_d;
  logic [IW-1:0]      best_idx;
  logic signed [15:0] best_mid;
  logic signed [15:0] best_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (cmd.start) begin
      first <= 1'b1;
    end else if (v3 && (first || dist3 < best_d)) begin
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (first || dist3 < best_d)) begin
      best_d   <= dist3;
      best_idx <= idx3;
      best_mid <= mid3;
      best_fin <= fin3;
    end
  end

  // floor sqrt of tx^2 + ty^2, one result bit per cycle
  logic [1:0]        rt_stage;
  logic [SQ_W-1:0]   rsx, rsy;
  logic [SQ_W-1:0]   rt_val;
  logic [19:0]       rem;
  logic [ROOT_W-1:0] root;
  logic [3:0]        iter;
  logic [19:0]       rem_sh;
  logic [19:0]       trial;
  logic [POS_W-1:0]  tax, tay;

  assign tax    = abs_diff(tx, '0);
  assign tay    = abs_diff(ty, '0);
  assign rem_sh = {rem[17:0], rt_val[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_stage <= RT_IDLE;
    end else begin
      case (rt_stage)
        RT_IDLE: begin
          if (cmd.start) begin
            rt_stage <= RT_SQ;
          end
        end
        RT_SQ:   rt_stage <= RT_SUM;
        RT_SUM:  rt_stage <= RT_ITER;
        RT_ITER: begin
          if (iter == '0) begin
            rt_stage <= RT_IDLE;
          end
        end
        default: rt_stage <= RT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (rt_stage)
      RT_SQ: begin
        rsx <= SQ_W'(tax) * SQ_W'(tax);
        rsy <= SQ_W'(tay) * SQ_W'(tay);
      end
      RT_SUM: begin
        rt_val <= rsx + rsy;
        rem    <= '0;
        root   <= '0;
        iter   <= 4'd15;
      end
      RT_ITER: begin
        rt_val <= {rt_val[SQ_W-3:0], 2'b00};
        iter   <= iter - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.publish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (empty) begin
        res_data <= '{table_empty: 1'b1, best_index: '0, arc_length: '0,
                      best_mid_curvature: '0, best_end_curvature: '0};
      end else begin
        res_data <= '{table_empty: 1'b0, best_index: 8'(best_idx), arc_length: root,
                      best_mid_curvature: best_mid, best_end_curvature: best_fin};
      end
    end
  end

  assign st.issue_left = (addr != count);
  assign st.busy       = v0 || v1 || v2 || v3 || (rt_stage != RT_IDLE);
  assign st.out_free   = !res_valid || res_ready;

endmodule

### hw/rtl/nearest_state_table_lookup.sv
// Load: stores the item in the table, no result. Query: N = min(entries_in_use, TABLE_DEPTH)
// table reads at one entry per cycle through a 4-stage distance pipeline, alongside a square
// root; the result is registered once both have finished and the output register is free.
// One query is in flight at a time; the next item is taken once the result is registered.
// Reset clears entries_in_use to 0 and the controller to idle; table contents are
// undefined until loaded.
module nearest_state_table_lookup import nst_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  nst_chan_if.sink   cfg,
  nst_chan_if.sink   req,
  nst_chan_if.source result
);

  dp_cmd_t    cmd;
  dp_status_t st;
  in_item_t   item;
  cfg_t       cfg_word;
  out_item_t  res_data;
  logic       res_valid;

  assign cfg.ready    = 1'b1;
  assign cfg_word     = cfg.data;
  assign item         = req.data;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  nst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_kind (item.kind),
    .req_ready(req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  nst_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg_word),
    .item     (item),
    .cmd      (cmd),
    .st       (st),
    .res_data (res_data),
    .res_valid(res_valid),
    .res_ready(result.ready)
  );

endmodule
